[rtl/tri_pkg.sv]
// ----------------------------------------------------------------------------
// tri_pkg
// Shared types and constants of the trapezoid row integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package tri_pkg;

    localparam int FLUX_W     = 16;
    localparam int ERR_W      = 16;
    localparam int STEP_W     = 16;
    localparam int ROWLEN_W   = 11;
    localparam int FINT_W     = 34;
    localparam int FERR_W     = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // multiplier second operand: signed, one bit above the step width
    localparam int MUL_B_W    = STEP_W + 1;

    // flux product is divided by 512, error product by 256
    localparam int FINT_SHIFT = 9;
    localparam int FERR_SHIFT = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd1;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 16'd256;
    localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = 11'd2;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SQ    = 8'b0000_0010,
        S_ACC   = 8'b0000_0100,
        S_FMUL  = 8'b0000_1000,
        S_ROOT  = 8'b0001_0000,
        S_SQRT  = 8'b0010_0000,
        S_EMUL  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

[rtl/tri_mul.sv]
// ----------------------------------------------------------------------------
// tri_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module tri_mul #(
    parameter int A_W = 28
) (
    input  wire                                  aclk,
    input  wire                                  en,
    input  wire signed [A_W-1:0]                 op_a,
    input  wire signed [tri_pkg::MUL_B_W-1:0]    op_b,
    output logic signed [A_W+tri_pkg::MUL_B_W-1:0] prod_reg
);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

endmodule

`default_nettype wire

[rtl/tri_sqrt.sv]
// ----------------------------------------------------------------------------
// tri_sqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tri_sqrt #(
    parameter int IN_W = 43
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start,
    input  wire  [IN_W-1:0]           radicand,
    output logic                      done_reg,
    output logic [(IN_W+1)/2-1:0]     root_reg
);

    localparam int ROOT_W = (IN_W + 1) / 2;
    localparam int X_W    = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [X_W-1:0]   x_reg;
    logic [REM_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [REM_W+1:0] rem_shift;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] subtrahend;

    always_comb begin
        rem_shift  = {rem_reg, x_reg[X_W-1 -: 2]};
        subtrahend = (REM_W + 2)'({root_reg, 2'b01});
        trial      = rem_shift - subtrahend;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= X_W'(radicand);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= {x_reg[X_W-3:0], 2'b00};
            // trial sign bit clear: subtraction fits, take a one
            if (!trial[REM_W+1]) begin
                rem_reg  <= trial[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_shift[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

`default_nettype wire

[rtl/trapezoid_row_integrator_top.sv]
// ----------------------------------------------------------------------------
// trapezoid_row_integrator_top
// Trapezoid rule integration of fixed-length rows of flux samples with a
// matching root of weighted error squares.
// ----------------------------------------------------------------------------
// channel   dir  handshake         payload
// s_        in   s_valid/s_ready   s_flux_sample, s_error_sample
// m_        out  m_valid/m_ready   m_flux_integral, m_flux_error
// cfg_      in   cfg_we            cfg_index, cfg_wdata
//
// Each sample passes through accept, square on the shared multiplier and
// accumulate. The last sample of a row then adds the flux product, the
// bit-serial square root and the error product.
// Reset is synchronous, active low; no clearing pass is needed.
// A finished result waits in the output register while the next row runs;
// the following result stalls until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module trapezoid_row_integrator_top #(
    parameter int MAX_ROW = 1024
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,

    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire signed [tri_pkg::FLUX_W-1:0]    s_flux_sample,
    input  wire  [tri_pkg::ERR_W-1:0]           s_error_sample,

    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic signed [tri_pkg::FINT_W-1:0]   m_flux_integral,
    output logic [tri_pkg::FERR_W-1:0]          m_flux_error,

    input  wire                                 cfg_we,
    input  wire  [tri_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire  [tri_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int POS_W   = $clog2(MAX_ROW);
    localparam int LEN_RAW = $clog2(MAX_ROW + 1);
    localparam int LEN_W   = (LEN_RAW > tri_pkg::ROWLEN_W) ? LEN_RAW : tri_pkg::ROWLEN_W;
    localparam int FSUM_W  = POS_W + tri_pkg::FLUX_W + 2;
    localparam int SQ_W    = POS_W + 2 * tri_pkg::ERR_W + 2;
    localparam int SQIN_W  = SQ_W - 1;
    localparam int ROOT_W  = (SQIN_W + 1) / 2;
    localparam int MA_0    = (FSUM_W > ROOT_W + 1) ? FSUM_W : ROOT_W + 1;
    localparam int MA_W    = (MA_0 > 27) ? MA_0 : 27;
    localparam int P_W     = MA_W + tri_pkg::MUL_B_W;

    tri_pkg::state_t state_reg, state_next;

    logic [tri_pkg::STEP_W-1:0]   step_reg;
    logic [tri_pkg::ROWLEN_W-1:0] rowlen_reg;
    logic [POS_W-1:0]             pos_reg;
    logic signed [FSUM_W-1:0]     fsum_reg;
    logic [SQ_W-1:0]              sqsum_reg;
    logic signed [tri_pkg::FLUX_W-1:0] flux_reg;
    logic [tri_pkg::ERR_W-1:0]    err_reg;
    logic                         first_reg;
    logic                         last_reg;
    logic signed [tri_pkg::FINT_W-1:0] fint_reg;
    logic                         m_valid_reg;
    logic signed [tri_pkg::FINT_W-1:0] m_fint_reg;
    logic [tri_pkg::FERR_W-1:0]   m_ferr_reg;

    logic [LEN_W-1:0]             rowlen_ext;
    logic [LEN_W-1:0]             eff_len;
    logic                         is_last;

    logic                         mul_en;
    logic signed [MA_W-1:0]       mul_a;
    logic signed [tri_pkg::MUL_B_W-1:0] mul_b;
    logic signed [P_W-1:0]        prod_reg;

    logic                         sqrt_start;
    logic                         sqrt_done;
    logic [ROOT_W-1:0]            root;

    logic signed [FSUM_W-1:0]     flux_add;
    logic [SQ_W-1:0]              sq_add;
    logic [2*tri_pkg::ERR_W-1:0]  sq_val;
    logic                         accept;
    logic                         out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // effective row length, clamped to 2..MAX_ROW
    always_comb begin
        rowlen_ext = LEN_W'(rowlen_reg);
        if (rowlen_ext < LEN_W'(2)) begin
            eff_len = LEN_W'(2);
        end else if (rowlen_ext > LEN_W'(MAX_ROW)) begin
            eff_len = LEN_W'(MAX_ROW);
        end else begin
            eff_len = rowlen_ext;
        end
        is_last = LEN_W'(pos_reg) >= (eff_len - 1'b1);
    end

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = {1'b0, step_reg};
        case (state_reg)
            tri_pkg::S_SQ: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(err_reg);
                mul_b  = {1'b0, err_reg};
            end
            tri_pkg::S_FMUL: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(fsum_reg);
            end
            tri_pkg::S_EMUL: begin
                mul_en = 1'b1;
                mul_a  = MA_W'(root);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    tri_mul #(
        .A_W      (MA_W)
    ) u_mul (
        .aclk     (aclk),
        .en       (mul_en),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod_reg (prod_reg)
    );

    assign sqrt_start = (state_reg == tri_pkg::S_ROOT);

    tri_sqrt #(
        .IN_W     (SQIN_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sqsum_reg[SQ_W-1:1]),
        .done_reg (sqrt_done),
        .root_reg (root)
    );

    // weighted terms: end samples once, inner samples twice
    always_comb begin
        sq_val = prod_reg[2*tri_pkg::ERR_W-1:0];
        if (first_reg || last_reg) begin
            flux_add = FSUM_W'(flux_reg);
            sq_add   = SQ_W'(sq_val);
        end else begin
            flux_add = FSUM_W'(flux_reg) <<< 1;
            sq_add   = SQ_W'(sq_val) << 1;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tri_pkg::S_IDLE: if (s_valid) state_next = tri_pkg::S_SQ;
            tri_pkg::S_SQ:   state_next = tri_pkg::S_ACC;
            tri_pkg::S_ACC:  state_next = last_reg ? tri_pkg::S_FMUL : tri_pkg::S_IDLE;
            tri_pkg::S_FMUL: state_next = tri_pkg::S_ROOT;
            tri_pkg::S_ROOT: state_next = tri_pkg::S_SQRT;
            tri_pkg::S_SQRT: if (sqrt_done) state_next = tri_pkg::S_EMUL;
            tri_pkg::S_EMUL: state_next = tri_pkg::S_OUT;
            tri_pkg::S_OUT:  if (out_free) state_next = tri_pkg::S_IDLE;
            default:         state_next = tri_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tri_pkg::S_IDLE;
            step_reg    <= tri_pkg::STEP_RESET;
            rowlen_reg  <= tri_pkg::ROWLEN_RESET;
            pos_reg     <= '0;
            fsum_reg    <= '0;
            sqsum_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == tri_pkg::CFG_STEP_SIZE) begin
                    step_reg <= cfg_wdata[tri_pkg::STEP_W-1:0];
                end else if (cfg_index == tri_pkg::CFG_ROW_LENGTH) begin
                    rowlen_reg <= cfg_wdata[tri_pkg::ROWLEN_W-1:0];
                end
            end
            if (state_reg == tri_pkg::S_ACC) begin
                fsum_reg  <= fsum_reg + flux_add;
                sqsum_reg <= sqsum_reg + sq_add;
                pos_reg   <= last_reg ? '0 : pos_reg + 1'b1;
            end
            if (state_reg == tri_pkg::S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
                fsum_reg    <= '0;
                sqsum_reg   <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            flux_reg  <= s_flux_sample;
            err_reg   <= s_error_sample;
            first_reg <= (pos_reg == '0);
            last_reg  <= is_last;
        end
        if (state_reg == tri_pkg::S_ROOT) begin
            // arithmetic shift gives floor division
            fint_reg <= prod_reg[tri_pkg::FINT_SHIFT +: tri_pkg::FINT_W];
        end
        if (state_reg == tri_pkg::S_OUT && out_free) begin
            m_fint_reg <= fint_reg;
            m_ferr_reg <= prod_reg[tri_pkg::FERR_SHIFT +: tri_pkg::FERR_W];
        end
    end

    assign s_ready         = (state_reg == tri_pkg::S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_flux_integral = m_fint_reg;
    assign m_flux_error    = m_ferr_reg;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == tri_pkg::S_OUT))
        else $error("result appeared outside the output step");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (LEN_W'(pos_reg) <= LEN_W'(MAX_ROW - 1)))
        else $error("sample position past row end");

    a_sqrt_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> (state_reg == tri_pkg::S_SQRT))
        else $error("square root finished outside its wait state");

    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tri_pkg::S_ACC && last_reg) |=> (pos_reg == '0))
        else $error("position not restarted after last item of row");

endmodule

`default_nettype wire

[tb/tb_trapezoid_row_integrator_top.sv]
// ----------------------------------------------------------------------------
// tb_trapezoid_row_integrator_top
// Self-checking bench for the trapezoid row integrator. Each accepted sample
// updates a local copy of the row sums; every row end queues the expected
// flux integral and flux error, which are compared in order against results.
// Directed rows hit the field extremes, the clamped row lengths and a
// mid-row length change. Random phases then vary step size, row length and
// the idle/stall pattern of both channels.
// ----------------------------------------------------------------------------

class row_integral_board;
    int max_row;
    logic [tri_pkg::STEP_W-1:0]   step_size;
    logic [tri_pkg::ROWLEN_W-1:0] row_length;
    int                  position;
    longint              flux_sum;
    longint              square_sum;
    logic signed [tri_pkg::FINT_W-1:0] integral_q[$];
    logic [tri_pkg::FERR_W-1:0]        error_q[$];
    int                  errors;

    function new(int max_row_len);
        max_row    = max_row_len;
        step_size  = tri_pkg::STEP_RESET;
        row_length = tri_pkg::ROWLEN_RESET;
        position   = 0;
        flux_sum   = 0;
        square_sum = 0;
        errors     = 0;
    endfunction

    function int row_span();
        int span;
        span = int'(row_length);
        if (span < 2) span = 2;
        if (span > max_row) span = max_row;
        return span;
    endfunction

    function void write_reg(logic [tri_pkg::CFG_IDX_W-1:0] idx,
                            logic [tri_pkg::CFG_DATA_W-1:0] data);
        if (idx == tri_pkg::CFG_STEP_SIZE) begin
            step_size = data[tri_pkg::STEP_W-1:0];
        end else if (idx == tri_pkg::CFG_ROW_LENGTH) begin
            row_length = data[tri_pkg::ROWLEN_W-1:0];
        end
    endfunction

    // bit-by-bit floor square root
    function longint floor_root(longint v);
        longint unsigned res;
        longint unsigned cand;
        res = 0;
        for (int b = 31; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (cand * cand <= longint'(v)) res = cand;
        end
        return longint'(res);
    endfunction

    function void take_sample(logic signed [tri_pkg::FLUX_W-1:0] flux,
                              logic [tri_pkg::ERR_W-1:0] err);
        longint f;
        longint sq;
        longint product;
        longint root;
        longint scaled;
        bit closing;
        logic signed [tri_pkg::FINT_W-1:0] fint;
        logic [tri_pkg::FERR_W-1:0] ferr;
        f  = longint'(flux);
        sq = longint'(err) * longint'(err);
        closing = (position >= row_span() - 1);
        // end samples weigh one, inner samples two
        if (position == 0 || closing) begin
            flux_sum   += f;
            square_sum += sq;
        end else begin
            flux_sum   += 2 * f;
            square_sum += 2 * sq;
        end
        if (!closing) begin
            position++;
            return;
        end
        product = flux_sum * longint'(step_size);
        scaled  = product >>> tri_pkg::FINT_SHIFT;
        fint    = scaled[tri_pkg::FINT_W-1:0];
        root    = floor_root(square_sum / 2);
        scaled  = (root * longint'(step_size)) >> tri_pkg::FERR_SHIFT;
        ferr    = scaled[tri_pkg::FERR_W-1:0];
        integral_q.push_back(fint);
        error_q.push_back(ferr);
        position   = 0;
        flux_sum   = 0;
        square_sum = 0;
    endfunction

    function void compare_row(logic signed [tri_pkg::FINT_W-1:0] fint,
                              logic [tri_pkg::FERR_W-1:0] ferr);
        logic signed [tri_pkg::FINT_W-1:0] exp_fint;
        logic [tri_pkg::FERR_W-1:0] exp_ferr;
        if (integral_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, flux_integral %0d flux_error %0d",
                     $time, fint, ferr);
            return;
        end
        exp_fint = integral_q.pop_front();
        exp_ferr = error_q.pop_front();
        if (fint !== exp_fint) begin
            errors++;
            $display("%0t: flux_integral expected %0d actual %0d", $time, exp_fint, fint);
        end
        if (ferr !== exp_ferr) begin
            errors++;
            $display("%0t: flux_error expected %0d actual %0d", $time, exp_ferr, ferr);
        end
    endfunction

    function int pending();
        return integral_q.size();
    endfunction
endclass

module tb_trapezoid_row_integrator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROW       = 1024;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int LONG_PHASE    = 3;
    localparam int SETTLE_CYCLES = 64;
    localparam int LIMIT_CYCLES  = 400000;

    // indexes past the register list, must be ignored
    localparam logic [tri_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tri_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    wire                               s_ready;
    logic signed [tri_pkg::FLUX_W-1:0] s_flux_sample;
    logic [tri_pkg::ERR_W-1:0]         s_error_sample;
    wire                               m_valid;
    logic                              m_ready;
    wire signed [tri_pkg::FINT_W-1:0]  m_flux_integral;
    wire [tri_pkg::FERR_W-1:0]         m_flux_error;
    logic                              cfg_we;
    logic [tri_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [tri_pkg::CFG_DATA_W-1:0]    cfg_wdata;

    int idle_pct;
    int stall_pct;
    int cycle_count;

    row_integral_board board;

    trapezoid_row_integrator_top #(
        .MAX_ROW(MAX_ROW)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_flux_sample  (s_flux_sample),
        .s_error_sample (s_error_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_flux_integral(m_flux_integral),
        .m_flux_error   (m_flux_error),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("trapezoid_row_integrator_top test failed");
            $finish;
        end
    end

    // result side: check on handshake, then draw the next ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.compare_row(m_flux_integral, m_flux_error);
        end
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic set_mode(int mode);
        case (mode)
            0: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            1: begin
                idle_pct  = 63;
                stall_pct = 0;
            end
            2: begin
                idle_pct  = 0;
                stall_pct = 63;
            end
            default: begin
                idle_pct  = 7;
                stall_pct = 7;
            end
        endcase
    endtask

    task automatic send_sample(logic signed [tri_pkg::FLUX_W-1:0] flux,
                               logic [tri_pkg::ERR_W-1:0] err);
        if ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < idle_pct);
        end
        s_valid        <= 1'b1;
        s_flux_sample  <= flux;
        s_error_sample <= err;
        do @(posedge aclk); while (!s_ready);
        board.take_sample(flux, err);
    endtask

    function automatic logic signed [tri_pkg::FLUX_W-1:0] draw_flux();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            default: return rnd[tri_pkg::FLUX_W-1:0];
        endcase
    endfunction

    function automatic logic [tri_pkg::ERR_W-1:0] draw_err();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return '0;
            2: return 16'd1;
            default: return rnd[tri_pkg::ERR_W-1:0];
        endcase
    endfunction

    function automatic logic [tri_pkg::CFG_DATA_W-1:0] rand_word();
        logic [31:0] rnd;
        rnd = $urandom;
        return rnd[tri_pkg::CFG_DATA_W-1:0];
    endfunction

    function automatic logic [tri_pkg::ROWLEN_W-1:0] pick_len(int lo, int hi);
        logic [31:0] rnd;
        rnd = $urandom_range(lo, hi);
        return rnd[tri_pkg::ROWLEN_W-1:0];
    endfunction

    task automatic send_row(int count);
        for (int i = 0; i < count; i++) begin
            send_sample(draw_flux(), draw_err());
        end
    endtask

    // drain all results and let the last sample finish before touching config
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [tri_pkg::CFG_IDX_W-1:0] idx,
                             logic [tri_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        board.write_reg(idx, data);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int span_of(logic [tri_pkg::ROWLEN_W-1:0] len);
        if (len < 2) return 2;
        if (len > MAX_ROW) return MAX_ROW;
        return int'(len);
    endfunction

    initial begin
        int sent;
        int phase;
        int span;
        int rows;
        logic [tri_pkg::ROWLEN_W-1:0] len;
        logic [tri_pkg::CFG_DATA_W-1:0] wdata;
        logic [31:0] rnd;

        board          = new(MAX_ROW);
        cycle_count    = 0;
        idle_pct       = 0;
        stall_pct      = 0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_flux_sample  <= '0;
        s_error_sample <= '0;
        m_ready        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= '0;
        cfg_wdata      <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset config first, then extremes and clamped lengths
        set_mode(3);
        send_sample(16'sh7FFF, 16'hFFFF);
        send_sample(16'sh7FFF, 16'hFFFF);
        send_sample(16'sh8000, 16'h0000);
        send_sample(16'sh8000, 16'hFFFF);
        send_sample(16'sh0000, 16'h0000);
        send_sample(-16'sd1, 16'h0001);
        settle();
        write_cfg(tri_pkg::CFG_STEP_SIZE, 16'hFFFF);
        write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'd0);
        send_sample(16'sh8000, 16'hFFFF);
        send_sample(16'sh8000, 16'hFFFF);
        send_sample(16'sh7FFF, 16'hFFFF);
        send_sample(16'sh7FFF, 16'h0000);
        settle();
        write_cfg(tri_pkg::CFG_STEP_SIZE, 16'h0000);
        write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'd1);
        write_cfg(CFG_SPARE_A, 16'h0005);
        send_sample(16'sd12345, 16'd54321);
        send_sample(-16'sd1, 16'hFFFF);
        settle();
        // odd step, negative sum: floor rounding
        write_cfg(tri_pkg::CFG_STEP_SIZE, 16'h0001);
        write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'd3);
        write_cfg(CFG_SPARE_B, 16'hFFFF);
        send_sample(16'sh8000, 16'hFFFF);
        send_sample(16'sh7FFF, 16'hFFFF);
        send_sample(16'sh8000, 16'hFFFF);
        settle();
        // shorten the row once two samples are in: next sample closes it
        write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'd5);
        send_sample(16'sd1000, 16'd300);
        send_sample(-16'sd2000, 16'd400);
        settle();
        write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'hF802);
        send_sample(16'sd77, 16'd500);
        settle();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            set_mode(phase % 4);
            case ($urandom_range(0, 5))
                0: write_cfg(tri_pkg::CFG_STEP_SIZE, 16'h0000);
                1: write_cfg(tri_pkg::CFG_STEP_SIZE, 16'hFFFF);
                2: write_cfg(tri_pkg::CFG_STEP_SIZE, tri_pkg::STEP_RESET);
                default: write_cfg(tri_pkg::CFG_STEP_SIZE, rand_word());
            endcase
            case ($urandom_range(0, 7))
                0: len = pick_len(0, 1);
                1: len = pick_len(2, 2);
                2, 3: len = pick_len(3, 8);
                4: len = pick_len(9, 48);
                default: len = pick_len(2, 16);
            endcase
            wdata = rand_word();
            wdata[tri_pkg::ROWLEN_W-1:0] = len;
            write_cfg(tri_pkg::CFG_ROW_LENGTH, wdata);
            if ($urandom_range(0, 3) == 0) begin
                write_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, rand_word());
            end
            span = span_of(len);
            rows = (span > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            for (int r = 0; r < rows; r++) begin
                send_row(span);
                sent += span;
            end
            // leave a row open so the next length write lands mid-row
            if ($urandom_range(0, 2) == 0) begin
                rows = $urandom_range(1, span - 1);
                send_row(rows);
                sent += rows;
            end
            settle();
            if (phase == LONG_PHASE) begin
                rnd = $urandom_range(49152, 65535);
                write_cfg(tri_pkg::CFG_STEP_SIZE, rnd[tri_pkg::CFG_DATA_W-1:0]);
                write_cfg(tri_pkg::CFG_ROW_LENGTH, 16'h07FF);
                send_row(MAX_ROW);
                sent += MAX_ROW;
                settle();
            end
            phase++;
        end

        settle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("trapezoid_row_integrator_top test passed");
        end else begin
            $display("trapezoid_row_integrator_top test failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/tri_pkg.sv
rtl/tri_mul.sv
rtl/tri_sqrt.sv
rtl/trapezoid_row_integrator_top.sv
tb/tb_trapezoid_row_integrator_top.sv
